/* design/keyed_quantity_table_top_macros.svh */
// Assertion macros for the keyed quantity table.
`ifndef KEYED_QUANTITY_TABLE_TOP_MACROS_SVH
`define KEYED_QUANTITY_TABLE_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on clk, quiet while rst is high.
`define KQT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kqt assertion failed");

// Next-cycle implication, checked on clk, quiet while rst is high.
`define KQT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kqt assertion failed");

`else

`define KQT_ASSERT_NOW(lbl, ante, cons)
`define KQT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* design/kqt_pkg.sv */
// Package: table sizing, operation and status codes, request and result types.
`default_nettype none

package kqt_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Operation codes
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EXISTS    = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [31:0] part_key;
    logic signed [31:0] quantity;
  } req_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] found_quantity;
    logic        [6:0]  entry_index;
    logic        [7:0]  entry_count;
  } rsp_t;

endpackage

`default_nettype wire

/* design/keyed_quantity_table_top.sv */
// Keyed quantity table: in-order filled key/quantity store with linear key search.
// Operation: a search, update or non-full insert scans the filled entries in slot order
//   and raises done when the key matches or the entries run out; an unused kind or an
//   insert into a full table answers without a scan. One stored key is read
//   per cycle into a single 32-bit comparator. Busy falls as done rises, so the block
//   takes no new request until it replies. Reset (rst, sync) empties the table.
`default_nettype none

`include "keyed_quantity_table_top_macros.svh"

module keyed_quantity_table_top
  import kqt_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic start,
  output logic       busy,
  input  wire  req_t req,
  output logic       done,
  output rsp_t       rsp
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state;

  // Request held for the whole scan
  req_t op;

  // Number of filled entries
  logic [CNT_W-1:0] count;

  // Scan pointer: next address to read; reaches count when every entry has been issued
  logic [CNT_W-1:0] scan_addr;

  // Registered read side of the key and quantity memories
  logic               rd_valid;
  logic [IDX_W-1:0]   rd_idx;
  logic signed [31:0] key_rd;
  logic signed [31:0] qty_rd;

  // Entry storage; contents are undefined until an insert writes a slot
  logic signed [31:0] key_mem [TABLE_DEPTH];
  logic signed [31:0] qty_mem [TABLE_DEPTH];

  logic               issue;
  logic               hit;
  logic               miss;
  logic               key_we;
  logic               qty_we;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   rd_addr;

  assign busy = (state != S_IDLE);

  // Issue a read while filled entries remain ahead of the pointer
  assign issue   = (scan_addr < count);
  assign rd_addr = scan_addr[IDX_W-1:0];

  // The one comparator: stored key read last cycle against the request key.
  // First match wins because entries come back in slot order.
  assign hit  = rd_valid && (key_rd == op.part_key);
  // Nothing in flight and nothing left to issue: the key is absent
  assign miss = !rd_valid && !issue;

  // Append on an insert miss; overwrite the quantity on an update hit
  assign key_we  = (state == S_SCAN) && miss && (op.kind == KIND_INSERT);
  assign qty_we  = key_we || ((state == S_SCAN) && hit && (op.kind == KIND_UPDATE));
  assign wr_addr = key_we ? count[IDX_W-1:0] : rd_idx;

  // Memory ports: one write and one registered read per array each cycle
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= op.part_key;
    end
    if (qty_we) begin
      qty_mem[wr_addr] <= op.quantity;
    end
    key_rd <= key_mem[rd_addr];
    qty_rd <= qty_mem[rd_addr];
  end

  // Sequencer, fill count and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      count     <= '0;
      scan_addr <= '0;
      rd_valid  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op        <= req;
            scan_addr <= '0;
            rd_valid  <= 1'b0;
            if (req.kind == KIND_INSERT && count >= CNT_W'(TABLE_DEPTH)) begin
              // Full table answers before any key check
              done                <= 1'b1;
              rsp.status          <= ST_FULL;
              rsp.found_quantity  <= '0;
              rsp.entry_index     <= '0;
              rsp.entry_count     <= 8'(count);
            end else if (req.kind == KIND_INSERT || req.kind == KIND_SEARCH ||
                         req.kind == KIND_UPDATE) begin
              state <= S_SCAN;
            end else begin
              // Unused kind: leave the table alone and report not found
              done                <= 1'b1;
              rsp.status          <= ST_NOT_FOUND;
              rsp.found_quantity  <= '0;
              rsp.entry_index     <= '0;
              rsp.entry_count     <= 8'(count);
            end
          end
        end

        S_SCAN: begin
          // Advance the pointer and track which slot the read data belongs to
          if (issue) begin
            scan_addr <= scan_addr + 1'b1;
          end
          rd_valid <= issue;
          rd_idx   <= rd_addr;

          if (hit) begin
            state               <= S_IDLE;
            rd_valid            <= 1'b0;
            done                <= 1'b1;
            rsp.status          <= (op.kind == KIND_INSERT) ? ST_EXISTS : ST_OK;
            rsp.found_quantity  <= (op.kind == KIND_SEARCH) ? qty_rd : '0;
            rsp.entry_index     <= 7'(rd_idx);
            rsp.entry_count     <= 8'(count);
          end else if (miss) begin
            state <= S_IDLE;
            done  <= 1'b1;
            rsp.found_quantity <= '0;
            if (op.kind == KIND_INSERT) begin
              // Append into the next free slot
              count           <= count + 1'b1;
              rsp.status      <= ST_OK;
              rsp.entry_index <= 7'(count);
              rsp.entry_count <= 8'(count + 1'b1);
            end else begin
              rsp.status      <= ST_NOT_FOUND;
              rsp.entry_index <= '0;
              rsp.entry_count <= 8'(count);
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted request is either answered at once or held in the scan
  `KQT_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)
  // The scan pointer never runs past the filled entries
  `KQT_ASSERT_NOW(a_scan_bound, state == S_SCAN, scan_addr <= count)
  // The fill count moves only together with a reported result
  `KQT_ASSERT_NOW(a_count_with_done, count != $past(count), done)
  // The reported count matches the table after the transfer
  `KQT_ASSERT_NOW(a_count_reported, done, rsp.entry_count == 8'(count))

endmodule

`default_nettype wire

/* verif/keyed_quantity_table_checker.sv */
// Checker for the keyed quantity table: predicts each reply and compares it field by field.
module keyed_quantity_table_checker
  import kqt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  input  logic done,
  input  rsp_t rsp,
  output int   fail_count,
  output int   outstanding
);

  logic signed [31:0] key_mem [TABLE_DEPTH];
  logic signed [31:0] qty_mem [TABLE_DEPTH];
  int   filled = 0;
  int   mismatches = 0;
  int   waiting = 0;
  rsp_t pending_replies [$];
  rsp_t want;

  assign fail_count  = mismatches;
  assign outstanding = waiting;

  // Apply one request to the table copy and return the reply it should produce.
  function automatic rsp_t table_reply(req_t r);
    rsp_t a;
    int   hit;
    a        = '0;
    a.status = ST_NOT_FOUND;
    hit      = -1;
    for (int i = 0; i < filled; i++) begin
      if (hit < 0 && key_mem[i] == r.part_key) hit = i;
    end
    case (r.kind)
      KIND_INSERT: begin
        if (filled >= TABLE_DEPTH) begin
          a.status = ST_FULL;
        end else if (hit >= 0) begin
          a.status      = ST_EXISTS;
          a.entry_index = 7'(hit);
        end else begin
          key_mem[filled] = r.part_key;
          qty_mem[filled] = r.quantity;
          a.entry_index   = 7'(filled);
          a.status        = ST_OK;
          filled++;
        end
      end
      KIND_SEARCH: begin
        if (hit >= 0) begin
          a.status         = ST_OK;
          a.entry_index    = 7'(hit);
          a.found_quantity = qty_mem[hit];
        end
      end
      KIND_UPDATE: begin
        if (hit >= 0) begin
          a.status      = ST_OK;
          a.entry_index = 7'(hit);
          qty_mem[hit]  = r.quantity;
        end
      end
      default: ;
    endcase
    a.entry_count = 8'(filled);
    return a;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      // Retire the reply first: a new request may be taken on the same edge.
      if (done) begin
        if (pending_replies.size() == 0) begin
          $error("reply with no request waiting");
          mismatches++;
        end else begin
          want = pending_replies.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            mismatches++;
          end
          if (rsp.found_quantity !== want.found_quantity) begin
            $error("found_quantity: expected %0d, got %0d",
                   want.found_quantity, rsp.found_quantity);
            mismatches++;
          end
          if (rsp.entry_index !== want.entry_index) begin
            $error("entry_index: expected %0d, got %0d", want.entry_index, rsp.entry_index);
            mismatches++;
          end
          if (rsp.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, rsp.entry_count);
            mismatches++;
          end
        end
      end
      if (start && !busy) pending_replies.push_back(table_reply(req));
    end
    waiting <= pending_replies.size();
  end

endmodule

/* verif/testbench.sv */
// Testbench top for the keyed quantity table: clock, reset, request stimulus and verdict.
module testbench;
  import kqt_pkg::*;

  // The package names only the three real operations; kind 3 is the unused code.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1330;
  // Drain time: covers a scan over a full table, with a margin.
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  rsp_t rsp;
  int   fail_count;
  int   outstanding;

  // Keys that went in through a successful insert, in slot order. Mirrors the table
  // exactly since an insert succeeds only when the key is new and a slot is free.
  logic signed [31:0] stocked_keys [$];

  always #5 clk = ~clk;

  keyed_quantity_table_top u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  keyed_quantity_table_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .rsp        (rsp),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // Draw a 32-bit word, with the extremes, zero and all-ones showing up often.
  function automatic logic signed [31:0] draw_word();
    case ($urandom_range(0, 19))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Build a request and track which keys end up stored.
  function automatic req_t make_req(logic [1:0] kind, logic signed [31:0] key,
                                    logic signed [31:0] qty);
    req_t r;
    bit   known;
    r.kind     = kind;
    r.part_key = key;
    r.quantity = qty;
    known      = 1'b0;
    foreach (stocked_keys[i]) if (stocked_keys[i] == key) known = 1'b1;
    if (kind == KIND_INSERT && !known && stocked_keys.size() < TABLE_DEPTH)
      stocked_keys.push_back(key);
    return r;
  endfunction

  // Mostly well-formed traffic: searches and updates aim at stored keys, inserts
  // mostly bring new keys so the table fills about halfway through the run.
  function automatic req_t random_req();
    int                 pick;
    bit                 aim_known;
    logic [1:0]         kind;
    logic signed [31:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 30)      kind = KIND_INSERT;
    else if (pick < 58) kind = KIND_SEARCH;
    else if (pick < 88) kind = KIND_UPDATE;
    else                kind = KIND_UNUSED;
    aim_known = (kind == KIND_INSERT) ? ($urandom_range(0, 3) == 0)
                                      : ($urandom_range(0, 3) != 0);
    if (aim_known && stocked_keys.size() > 0)
      key = stocked_keys[$urandom_range(0, stocked_keys.size() - 1)];
    else
      key = draw_word();
    return make_req(kind, key, draw_word());
  endfunction

  // Hold start high with the request until the block takes it. Leave start high
  // afterwards so a back-to-back transfer needs no second assignment in the step.
  task automatic issue(input req_t r);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and put junk on the request bus for the length of the pause.
  task automatic pause(input int n);
    start <= 1'b0;
    req   <= '{kind: 2'($urandom), part_key: $urandom, quantity: $urandom};
    repeat (n) @(posedge clk);
  endtask

  // Ends a run that hangs.
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int sent;
    int burst;
    sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table first, then extreme keys and quantities.
    issue(make_req(KIND_SEARCH, 32'sd0, 32'sd0));
    issue(make_req(KIND_UPDATE, WORD_MAX, 32'sd5));
    issue(make_req(KIND_UNUSED, 32'sd0, 32'sd0));
    issue(make_req(KIND_INSERT, WORD_MIN, WORD_MAX));
    issue(make_req(KIND_INSERT, WORD_MAX, WORD_MIN));
    pause(3);
    issue(make_req(KIND_INSERT, 32'sd0, 32'sd0));
    issue(make_req(KIND_INSERT, -32'sd1, -32'sd1));
    // Duplicate insert: must report the existing slot and leave the table alone.
    issue(make_req(KIND_INSERT, WORD_MIN, 32'sd77));
    issue(make_req(KIND_SEARCH, WORD_MIN, 32'sd0));
    issue(make_req(KIND_SEARCH, WORD_MAX, 32'sd0));
    issue(make_req(KIND_SEARCH, -32'sd1, 32'sd0));
    issue(make_req(KIND_UPDATE, -32'sd1, WORD_MAX));
    issue(make_req(KIND_SEARCH, -32'sd1, 32'sd0));
    issue(make_req(KIND_UPDATE, 32'sd0, WORD_MIN));
    issue(make_req(KIND_SEARCH, 32'sd0, 32'sd0));
    pause(1);
    // Unused kind on a stored key: answers not found and changes nothing.
    issue(make_req(KIND_UNUSED, WORD_MAX, 32'sd9));
    issue(make_req(KIND_SEARCH, WORD_MAX, 32'sd0));
    issue(make_req(KIND_UPDATE, 32'sd12345, 32'sd1));
    issue(make_req(KIND_SEARCH, 32'sd12345, 32'sd0));

    // Random: bursts of back-to-back transfers, mostly followed by a short or long
    // idle gap with start low and junk on the request bus.
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        issue(random_req());
        sent++;
      end
      if ($urandom_range(0, 3) != 0)
        pause(($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6));
    end
    start <= 1'b0;

    // Drain: wait for the last reply, then give stray replies time to show.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/kqt_pkg.sv
design/keyed_quantity_table_top.sv
verif/keyed_quantity_table_checker.sv
verif/testbench.sv
